/* hdl/gdn_pkg.sv */
// Shared constants, command and status types, and calendar helpers for the day number converter.
package gdn_pkg;

	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int DN_W     = 22;
	localparam int ACC_W    = 23;
	localparam int DATA_W   = 48;
	localparam int OP_W     = 4;
	localparam int BIT_W    = 3;
	localparam int QUOT_W   = 8;
	localparam int QUAD_W   = 5;
	localparam int CNT_W    = 2;

	// Field positions inside tdata, lowest field first.
	localparam int DAY_LSB   = 0;
	localparam int MONTH_LSB = DAY_LSB + DAY_W;
	localparam int YEAR_LSB  = MONTH_LSB + MONTH_W;
	localparam int DN_LSB    = YEAR_LSB + YEAR_W;
	localparam int PAD_W     = DATA_W - DN_LSB - DN_W;

	localparam logic [ACC_W-1:0]  CYCLE_DAYS  = 23'd146097;
	localparam logic [ACC_W-1:0]  CENT_DAYS   = 23'd36524;
	localparam logic [ACC_W-1:0]  QUAD_DAYS   = 23'd1461;
	localparam logic [ACC_W-1:0]  YEAR_DAYS   = 23'd365;
	localparam logic [YEAR_W-1:0] CYCLE_YEARS = 14'd400;
	localparam logic [YEAR_W-1:0] CENT_YEARS  = 14'd100;
	localparam logic [YEAR_W-1:0] QUAD_YEARS  = 14'd4;
	localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;
	localparam logic [QUAD_W-1:0] LAST_QUAD   = 5'd24;
	localparam logic [CNT_W-1:0]  MAX_CNT     = 2'd3;
	localparam logic [BIT_W-1:0]  TOP_BIT     = 3'd4;

	// Reciprocal of 25 scaled by 2^17; exact for the 12-bit operands used here.
	localparam logic [12:0] RECIP_25  = 13'd5243;
	localparam int          RECIP_SH  = 17;

	// Datapath operations.
	localparam logic [OP_W-1:0] OP_NONE = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD = 4'd1;
	localparam logic [OP_W-1:0] OP_DIV  = 4'd2;
	localparam logic [OP_W-1:0] OP_BASE = 4'd3;
	localparam logic [OP_W-1:0] OP_MON  = 4'd4;
	localparam logic [OP_W-1:0] OP_DAY  = 4'd5;
	localparam logic [OP_W-1:0] OP_CYC  = 4'd6;
	localparam logic [OP_W-1:0] OP_CEN  = 4'd7;
	localparam logic [OP_W-1:0] OP_QUAD = 4'd8;
	localparam logic [OP_W-1:0] OP_YR   = 4'd9;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [BIT_W-1:0] bit_idx;
		logic             out_load;
	} cmd_t;

	typedef struct packed {
		logic func;
		logic cen_go;
		logic yr_go;
		logic mon_go;
	} status_t;

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mo,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (mo)
			4'd2: begin
				len = leap ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				len = 5'd30;
			end
			default: begin
				len = 5'd31;
			end
		endcase
		return len;
	endfunction

	function automatic logic [QUOT_W-1:0] div25(input logic [11:0] x);
		logic [24:0] prod;
		prod = 25'(x) * 25'(RECIP_25);
		return QUOT_W'(prod >> RECIP_SH);
	endfunction

endpackage

/* hdl/gdn_ctrl.sv */
// Sequencer that steps the datapath through one conversion and owns the handshakes.
module gdn_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_func,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  gdn_pkg::status_t status,
	output gdn_pkg::cmd_t    cmd
);
	import gdn_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIV  = 4'd1;
	localparam logic [3:0] ST_BASE = 4'd2;
	localparam logic [3:0] ST_MON  = 4'd3;
	localparam logic [3:0] ST_DAY  = 4'd4;
	localparam logic [3:0] ST_CYC  = 4'd5;
	localparam logic [3:0] ST_CEN  = 4'd6;
	localparam logic [3:0] ST_QUAD = 4'd7;
	localparam logic [3:0] ST_YR   = 4'd8;
	localparam logic [3:0] ST_DONE = 4'd9;

	logic [3:0]       state_q;
	logic [3:0]       state_next;
	logic [BIT_W-1:0] bit_q;
	logic             out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_next   = state_q;
		cmd.op       = OP_NONE;
		cmd.bit_idx  = bit_q;
		cmd.out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op     = OP_LOAD;
					state_next = in_func ? ST_CYC : ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.op     = OP_DIV;
				state_next = ST_BASE;
			end
			ST_BASE: begin
				cmd.op     = OP_BASE;
				state_next = ST_MON;
			end
			ST_MON: begin
				if (status.mon_go) begin
					cmd.op = OP_MON;
				end else begin
					state_next = status.func ? ST_DONE : ST_DAY;
				end
			end
			ST_DAY: begin
				cmd.op     = OP_DAY;
				state_next = ST_DONE;
			end
			ST_CYC: begin
				cmd.op = OP_CYC;
				if (bit_q == '0) begin
					state_next = ST_CEN;
				end
			end
			ST_CEN: begin
				if (status.cen_go) begin
					cmd.op = OP_CEN;
				end else begin
					state_next = ST_QUAD;
				end
			end
			ST_QUAD: begin
				cmd.op = OP_QUAD;
				if (bit_q == '0) begin
					state_next = ST_YR;
				end
			end
			ST_YR: begin
				if (status.yr_go) begin
					cmd.op = OP_YR;
				end else begin
					state_next = ST_MON;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_q       <= TOP_BIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			// The bit index restarts before each restoring division pass.
			if (state_q == ST_IDLE || state_q == ST_CEN) begin
				bit_q <= TOP_BIT;
			end else if (state_q == ST_CYC || state_q == ST_QUAD) begin
				bit_q <= bit_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hdl/gdn_dpath.sv */
// Datapath: day accumulator, year and month counters, calendar arithmetic and result register.
module gdn_dpath (
	input  logic                         clk,
	input  gdn_pkg::cmd_t                cmd,
	input  logic                         in_func,
	input  logic [gdn_pkg::DATA_W-1:0]   in_data,
	output gdn_pkg::status_t             status,
	output logic [gdn_pkg::DATA_W-1:0]   out_data
);
	import gdn_pkg::*;

	logic                func_q;
	logic [DAY_W-1:0]    day_q;
	logic [MONTH_W-1:0]  mon_q;
	logic [YEAR_W-1:0]   year_q;
	logic [ACC_W-1:0]    acc_q;
	logic [YEAR_W-1:0]   yr_q;
	logic [MONTH_W-1:0]  mo_q;
	logic [CNT_W-1:0]    cen_q;
	logic [CNT_W-1:0]    yy_q;
	logic [QUAD_W-1:0]   quad_q;
	logic [QUOT_W-1:0]   tmp_q;
	logic [QUOT_W-1:0]   yq_q;
	logic                leap_q;

	logic [DAY_W-1:0]    res_day_q;
	logic [MONTH_W-1:0]  res_month_q;
	logic [YEAR_W-1:0]   res_year_q;
	logic [DN_W-1:0]     res_dn_q;

	logic [DAY_W-1:0]    in_day;
	logic [MONTH_W-1:0]  in_month;
	logic [YEAR_W-1:0]   in_year;
	logic [DN_W-1:0]     in_dn;
	logic [MONTH_W-1:0]  month_clamp;

	logic [YEAR_W-1:0]   p;
	logic [ACC_W-1:0]    base_sum;
	logic                cent_exact;
	logic                leap_d;
	logic                leap_n;
	logic                leap_m;
	logic [ACC_W-1:0]    mdays;
	logic [ACC_W-1:0]    cyc_sub;
	logic [ACC_W-1:0]    quad_sub;

	assign in_day   = in_data[DAY_LSB +: DAY_W];
	assign in_month = in_data[MONTH_LSB +: MONTH_W];
	assign in_year  = in_data[YEAR_LSB +: YEAR_W];
	assign in_dn    = in_data[DN_LSB +: DN_W];

	always_comb begin
		if (in_month == '0) begin
			month_clamp = 4'd1;
		end else if (in_month > LAST_MONTH) begin
			month_clamp = LAST_MONTH;
		end else begin
			month_clamp = in_month;
		end
	end

	// Year zero counts no earlier years.
	assign p = (year_q == '0) ? '0 : year_q - 1'b1;

	// p/100 and p/400 are derived from tmp_q = p/100.
	assign base_sum = ACC_W'(p) * YEAR_DAYS + ACC_W'(p[YEAR_W-1:2]) - ACC_W'(tmp_q)
		+ ACC_W'(tmp_q[QUOT_W-1:2]);

	assign cent_exact = (year_q == YEAR_W'(YEAR_W'(yq_q) * CENT_YEARS));
	assign leap_d     = (year_q[1:0] == 2'b00) && (!cent_exact || yq_q[1:0] == 2'b00);

	// The fourth year of a four-year block is leap, except at a century
	// that is not the fourth of its 400-year cycle.
	assign leap_n = (yy_q == MAX_CNT) && (quad_q != LAST_QUAD || cen_q == MAX_CNT);
	assign leap_m = func_q ? leap_n : leap_q;
	assign mdays  = ACC_W'(month_days(mo_q, leap_m));

	assign cyc_sub  = CYCLE_DAYS << cmd.bit_idx;
	assign quad_sub = QUAD_DAYS << cmd.bit_idx;

	assign status.func   = func_q;
	assign status.cen_go = (cen_q != MAX_CNT) && (acc_q >= CENT_DAYS);
	assign status.yr_go  = (yy_q != MAX_CNT) && (acc_q >= YEAR_DAYS);
	assign status.mon_go = func_q ? ((mo_q < LAST_MONTH) && (acc_q >= mdays))
		: (mo_q < mon_q);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				func_q <= in_func;
				day_q  <= in_day;
				mon_q  <= month_clamp;
				year_q <= in_year;
				acc_q  <= (in_dn == '0) ? '0 : ACC_W'(in_dn) - 1'b1;
				yr_q   <= 14'd1;
				mo_q   <= 4'd1;
				cen_q  <= '0;
				yy_q   <= '0;
				quad_q <= '0;
			end
			OP_DIV: begin
				tmp_q <= div25(p[YEAR_W-1:2]);
				yq_q  <= div25(year_q[YEAR_W-1:2]);
			end
			OP_BASE: begin
				acc_q  <= base_sum;
				leap_q <= leap_d;
			end
			OP_MON: begin
				mo_q  <= mo_q + 1'b1;
				acc_q <= func_q ? acc_q - mdays : acc_q + mdays;
			end
			OP_DAY: begin
				acc_q <= acc_q + ACC_W'(day_q);
			end
			OP_CYC: begin
				if (acc_q >= cyc_sub) begin
					acc_q <= acc_q - cyc_sub;
					yr_q  <= yr_q + (CYCLE_YEARS << cmd.bit_idx);
				end
			end
			OP_CEN: begin
				acc_q <= acc_q - CENT_DAYS;
				yr_q  <= yr_q + CENT_YEARS;
				cen_q <= cen_q + 1'b1;
			end
			OP_QUAD: begin
				if (acc_q >= quad_sub) begin
					acc_q  <= acc_q - quad_sub;
					yr_q   <= yr_q + (QUAD_YEARS << cmd.bit_idx);
					quad_q <= quad_q + (QUAD_W'(1) << cmd.bit_idx);
				end
			end
			OP_YR: begin
				acc_q <= acc_q - YEAR_DAYS;
				yr_q  <= yr_q + 1'b1;
				yy_q  <= yy_q + 1'b1;
			end
			default: begin
			end
		endcase

		if (cmd.out_load) begin
			if (func_q) begin
				res_day_q   <= acc_q[DAY_W-1:0] + 1'b1;
				res_month_q <= mo_q;
				res_year_q  <= yr_q;
				res_dn_q    <= '0;
			end else begin
				res_day_q   <= '0;
				res_month_q <= '0;
				res_year_q  <= '0;
				res_dn_q    <= acc_q[DN_W-1:0];
			end
		end
	end

	assign out_data = {{PAD_W{1'b0}}, res_dn_q, res_year_q, res_month_q, res_day_q};

endmodule

/* hdl/gregorian_day_number_convert.sv */
// Top level of the proleptic Gregorian date and day number converter.
//
// Converts a date to its day number (tuser 0) or a day number back to a date
// (tuser 1), with 0001-01-01 as day 1. One conversion runs at a time; the next
// transaction is taken the cycle after the result moves into the output
// register, even while that result still waits for the sink. A date to day
// number conversion runs two arithmetic steps, one month step per earlier
// month (up to 11), the day add and the hand-off. A day number to date
// conversion runs five restoring steps for the 400-year cycles, the century
// steps, five steps for four-year blocks, the year steps, the month steps
// and the hand-off. The month walk sets the variable part of a date to day
// number run; the century, year and month walks set that of the other.
module gregorian_day_number_convert (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// day[4:0], month[8:5], year[22:9], day_number[44:23], zero pad [47:45]
	input  logic [gdn_pkg::DATA_W-1:0] s_axis_tdata,
	// func: 0 date to day number, 1 day number to date
	input  logic                       s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// res_day[4:0], res_month[8:5], res_year[22:9], res_day_number[44:23], zero pad [47:45]
	output logic [gdn_pkg::DATA_W-1:0] m_axis_tdata
);
	import gdn_pkg::*;

	cmd_t    cmd;
	status_t status;

	gdn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_func   (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	gdn_dpath u_dpath (
		.clk      (clk),
		.cmd      (cmd),
		.in_func  (s_axis_tuser),
		.in_data  (s_axis_tdata),
		.status   (status),
		.out_data (m_axis_tdata)
	);

endmodule
